FILE: hdl/sapc_pkg.sv
// sapc_pkg: shared constants, control word and status types, and the microcode
// program of the sensor average / polynomial calibration block
// depends on nothing; every other file of the block uses it by scoped names
`default_nettype none

package sapc_pkg;

  // default configuration
  localparam int NUM_CHANNELS_DEF = 10;
  localparam int WINDOW_DEF       = 5;
  localparam int NUM_COEFFS       = 6;

  // field widths
  localparam int CH_W   = 4;
  localparam int RAW_W  = 16;
  localparam int IDX_W  = 3;
  localparam int COEF_W = 32;
  localparam int VOLT_W = 19;
  localparam int FRAC_W = 16;

  // horner accumulator and its split for the shared multiplier
  localparam int ACC_W  = 48;
  localparam int HALF_W = ACC_W / 2;

  localparam int VOLT_MAX   = 327680;
  localparam int ROUND_HALF = 32768;

  localparam logic signed [COEF_W-1:0] DISP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] DISP_MIN = 32'sh8000_0000;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  // sequencer
  localparam int PC_W  = 4;
  localparam int CNT_W = 5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_UPDATE,
    OP_PREP,
    OP_DIV,
    OP_LOADC,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_START,
    COND_LOOP,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             cnt_load;
    logic [CNT_W-1:0] cnt_init;
    logic             last;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic out_busy;
  } status_t;

  localparam logic [PC_W-1:0] STEP_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] STEP_UPDATE = 4'd1;
  localparam logic [PC_W-1:0] STEP_PREP   = 4'd2;
  localparam logic [PC_W-1:0] STEP_DIV    = 4'd3;
  localparam logic [PC_W-1:0] STEP_LOADC  = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_LO = 4'd5;
  localparam logic [PC_W-1:0] STEP_MUL_HI = 4'd6;
  localparam logic [PC_W-1:0] STEP_ACC    = 4'd7;
  localparam logic [PC_W-1:0] STEP_EMIT   = 4'd8;
  localparam logic [PC_W-1:0] LAST_STEP   = STEP_EMIT;

  // loop counts minus one: one quotient bit per divide step, five horner steps
  localparam logic [CNT_W-1:0] DIV_ITERS_M1    = CNT_W'(VOLT_W - 1);
  localparam logic [CNT_W-1:0] HORNER_ITERS_M1 = CNT_W'(NUM_COEFFS - 2);

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w.op       = OP_NOP;
    w.cond     = COND_NONE;
    w.target   = STEP_FETCH;
    w.cnt_load = 1'b0;
    w.cnt_init = '0;
    w.last     = 1'b0;
    case (pc)
      STEP_FETCH: begin
        w.op     = OP_FETCH;
        w.cond   = COND_NO_START;
        w.target = STEP_FETCH;
      end
      STEP_UPDATE: begin
        w.op = OP_UPDATE;
      end
      STEP_PREP: begin
        w.op       = OP_PREP;
        w.cnt_load = 1'b1;
        w.cnt_init = DIV_ITERS_M1;
      end
      STEP_DIV: begin
        w.op     = OP_DIV;
        w.cond   = COND_LOOP;
        w.target = STEP_DIV;
      end
      STEP_LOADC: begin
        w.op       = OP_LOADC;
        w.cnt_load = 1'b1;
        w.cnt_init = HORNER_ITERS_M1;
      end
      STEP_MUL_LO: begin
        w.op = OP_MUL_LO;
      end
      STEP_MUL_HI: begin
        w.op = OP_MUL_HI;
      end
      STEP_ACC: begin
        w.op     = OP_ACC;
        w.cond   = COND_LOOP;
        w.target = STEP_MUL_LO;
      end
      STEP_EMIT: begin
        w.op     = OP_EMIT;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sapc_req_if.sv
// sapc_req_if: request channel (samples and coefficient writes)
// depends on sapc_pkg for field widths
`default_nettype none

interface sapc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [sapc_pkg::CH_W-1:0]            channel;
  logic [sapc_pkg::RAW_W-1:0]           raw_sample;
  logic [sapc_pkg::IDX_W-1:0]           coeff_index;
  logic signed [sapc_pkg::COEF_W-1:0]   coeff_value;

  modport source (
    output valid, req_type, channel, raw_sample, coeff_index, coeff_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, channel, raw_sample, coeff_index, coeff_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/sapc_rsp_if.sv
// sapc_rsp_if: result channel (averaged voltage and calibrated displacement)
// depends on sapc_pkg for field widths
`default_nettype none

interface sapc_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [sapc_pkg::CH_W-1:0]            out_channel;
  logic [sapc_pkg::VOLT_W-1:0]          avg_volt;
  logic signed [sapc_pkg::COEF_W-1:0]   displacement;
  logic                                 saturated;

  modport source (
    output valid, out_channel, avg_volt, displacement, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_channel, avg_volt, displacement, saturated,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/sensor_average_poly_calibrate_top.sv
// sensor_average_poly_calibrate_top: top level of the sensor conditioner
// depends on sapc_pkg, sapc_req_if, sapc_rsp_if, sapc_seq and sapc_dp
`default_nettype none

// Multi-channel displacement sensor conditioner. A request is either a raw
// 16-bit sample for a channel or a write of one of that channel's six signed
// Q16.16 calibration coefficients (index 0 is the fifth-power term, index 5 the
// constant). Each sample enters a per-channel moving window of up to WINDOW
// samples; the window sum over the fill count, scaled by 5/65535 and rounded,
// gives avg_volt in unsigned Q3.16. That voltage drives a fifth-order
// polynomial (Horner form, rounded at each step) whose result is clipped to
// signed Q16.16, with saturated set when clipping happened. Coefficients read
// as zero until written. Coefficient writes, and any request for a channel at
// or beyond NUM_CHANNELS, produce no result. A sample passes through the window
// update, the one-bit-per-cycle divider that forms the average, and five Horner
// steps (a low product, a high product and an accumulate each) on the single
// shared 25x20 multiplier, and then its result is emitted; no new request is
// taken until then, and a stalled result holds the block at the last step. No
// clearing pass is needed after reset.
module sensor_average_poly_calibrate_top #(
  parameter int NUM_CHANNELS = sapc_pkg::NUM_CHANNELS_DEF,
  parameter int WINDOW       = sapc_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sapc_req_if.sink    req,
  sapc_rsp_if.source  rsp
);

  sapc_pkg::ctrl_t   ctrl;
  sapc_pkg::status_t status;

  sapc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  sapc_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW       (WINDOW)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .ctrl   (ctrl),
    .status (status)
  );

endmodule

`default_nettype wire

FILE: hdl/sapc_ram.sv
// sapc_ram: generic single-clock ram, one write port, one registered read port
// depends on sapc_pkg for default sizes
`default_nettype none

module sapc_ram #(
  parameter int WIDTH = sapc_pkg::COEF_W,
  parameter int DEPTH = sapc_pkg::NUM_CHANNELS_DEF * sapc_pkg::NUM_COEFFS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sapc_seq.sv
// sapc_seq: step counter, loop counter and control store lookup
// depends on sapc_pkg for the program and the control and status types
`default_nettype none

module sapc_seq (
  input  logic                clk,
  input  logic                rst,
  input  sapc_pkg::status_t   status,
  output sapc_pkg::ctrl_t     ctrl
);

  logic [sapc_pkg::PC_W-1:0]  pc;
  logic [sapc_pkg::PC_W-1:0]  pc_next;
  logic [sapc_pkg::CNT_W-1:0] cnt;
  logic [sapc_pkg::CNT_W-1:0] cnt_next;
  logic                       jump;

  assign ctrl = sapc_pkg::ucode(pc);

  always_comb begin
    case (ctrl.cond)
      sapc_pkg::COND_NO_START: jump = !status.start;
      sapc_pkg::COND_LOOP:     jump = (cnt != '0);
      sapc_pkg::COND_OUT_BUSY: jump = status.out_busy;
      default:                 jump = 1'b0;
    endcase

    if (jump) begin
      pc_next = ctrl.target;
    end else if (ctrl.last) begin
      pc_next = sapc_pkg::STEP_FETCH;
    end else begin
      pc_next = pc + 1'b1;
    end

    if (ctrl.cnt_load) begin
      cnt_next = ctrl.cnt_init;
    end else if (ctrl.cond == sapc_pkg::COND_LOOP) begin
      cnt_next = cnt - 1'b1;
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= sapc_pkg::STEP_FETCH;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

`ifndef SYNTH
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= sapc_pkg::LAST_STEP)
    else $error("step counter left the program");

  a_start_goes_update: assert property (@(posedge clk) disable iff (rst)
    status.start |=> pc == sapc_pkg::STEP_UPDATE)
    else $error("accepted sample did not enter the window update");
`endif

endmodule

`default_nettype wire

FILE: hdl/sapc_dp.sv
// sapc_dp: datapath of the conditioner: window state, sample and coefficient
// rams, bit-serial divider, shared multiplier for horner, output register
// depends on sapc_pkg, sapc_req_if, sapc_rsp_if and sapc_ram
`default_nettype none

module sapc_dp #(
  parameter int NUM_CHANNELS = sapc_pkg::NUM_CHANNELS_DEF,
  parameter int WINDOW       = sapc_pkg::WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sapc_req_if.sink          req,
  sapc_rsp_if.source        rsp,
  input  sapc_pkg::ctrl_t   ctrl,
  output sapc_pkg::status_t status
);

  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W      = sapc_pkg::RAW_W + FILL_W;
  localparam int DEN_W      = sapc_pkg::RAW_W + FILL_W;
  localparam int NUM_W      = SUM_W + sapc_pkg::VOLT_W;
  localparam int CI_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int WIN_DEPTH  = NUM_CHANNELS * WINDOW;
  localparam int WA_W       = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int COEF_DEPTH = NUM_CHANNELS * sapc_pkg::NUM_COEFFS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int ACC_W      = sapc_pkg::ACC_W;
  localparam int HALF_W     = sapc_pkg::HALF_W;
  localparam int VOLT_W     = sapc_pkg::VOLT_W;
  localparam int COEF_W     = sapc_pkg::COEF_W;
  localparam int FRAC_W     = sapc_pkg::FRAC_W;
  localparam int PROD_W     = HALF_W + 1 + VOLT_W + 1;
  localparam int PL_W       = HALF_W + VOLT_W;
  localparam int PART_W     = PL_W + 1;
  localparam int HI_SHIFT   = HALF_W - FRAC_W;

  // ---------------------------------------------------------------- fetch
  logic                         accept;
  logic                         ch_ok;
  logic                         coef_we;
  logic [CA_W-1:0]              coef_waddr;
  logic [POS_W-1:0]             pos_rd;
  logic [WA_W-1:0]              win_raddr;

  // per-channel window state
  logic [POS_W-1:0]             pos_arr  [NUM_CHANNELS];
  logic [FILL_W-1:0]            fill_arr [NUM_CHANNELS];
  logic [SUM_W-1:0]             sum_arr  [NUM_CHANNELS];
  logic [COEF_DEPTH-1:0]        coef_vld;

  // item registers
  logic [sapc_pkg::CH_W-1:0]    ch_q;
  logic [sapc_pkg::RAW_W-1:0]   raw_q;
  logic [WA_W-1:0]              waddr_q;
  logic [SUM_W-1:0]             sum_q;
  logic [FILL_W-1:0]            fill_q;
  logic [DEN_W-1:0]             den_q;
  logic [DEN_W-1:0]             rem_q;
  logic [VOLT_W-1:0]            numlo_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic [PART_W-1:0]            part_q;
  logic [sapc_pkg::IDX_W-1:0]   k_q;
  logic                         cvld_q;

  // update step
  logic [CI_W-1:0]              ci;
  logic [FILL_W-1:0]            fill_cur;
  logic [SUM_W-1:0]             sum_cur;
  logic [POS_W-1:0]             pos_cur;
  logic [FILL_W-1:0]            fill_new;
  logic [SUM_W-1:0]             sum_new;
  logic [POS_W-1:0]             pos_new;
  logic [sapc_pkg::RAW_W-1:0]   win_rdata;

  // prep and divide
  logic [SUM_W+2:0]             sum5;
  logic [DEN_W-1:0]             den;
  logic [NUM_W-1:0]             num;
  logic [DEN_W:0]               rem2;
  logic                         qbit;

  // horner
  logic                         coef_re;
  logic [sapc_pkg::IDX_W-1:0]   idx_rd;
  logic [CA_W-1:0]              coef_raddr;
  logic [COEF_W-1:0]            coef_rdata;
  logic signed [COEF_W-1:0]     coef_val;
  logic signed [VOLT_W:0]       volt_s;
  logic signed [ACC_W-1:0]      prod_ext;
  logic signed [ACC_W-1:0]      part_ext;
  logic signed [ACC_W-1:0]      coef_ext;
  logic signed [ACC_W-1:0]      acc_next;

  // emit
  logic                         fits;
  logic signed [COEF_W-1:0]     disp_sat;
  logic                         out_busy;
  logic                         out_valid;
  logic [sapc_pkg::CH_W-1:0]    out_channel;
  logic [VOLT_W-1:0]            out_volt;
  logic signed [COEF_W-1:0]     out_disp;
  logic                         out_sat;

  assign req.ready = (ctrl.op == sapc_pkg::OP_FETCH);
  assign accept    = req.valid && req.ready;
  assign ch_ok     = {1'b0, req.channel} < (sapc_pkg::CH_W + 1)'(NUM_CHANNELS);

  assign status.start    = accept && ch_ok && (req.req_type == sapc_pkg::REQ_SAMPLE);
  assign coef_we         = accept && ch_ok && (req.req_type == sapc_pkg::REQ_COEFF) &&
                           (req.coeff_index < sapc_pkg::IDX_W'(sapc_pkg::NUM_COEFFS));
  assign coef_waddr      = CA_W'(req.channel) * CA_W'(sapc_pkg::NUM_COEFFS) +
                           CA_W'(req.coeff_index);
  assign pos_rd          = pos_arr[req.channel[CI_W-1:0]];
  assign win_raddr       = WA_W'(req.channel) * WA_W'(WINDOW) + WA_W'(pos_rd);

  // window update: the fill count guards the read of the evicted sample
  assign ci       = ch_q[CI_W-1:0];
  assign fill_cur = fill_arr[ci];
  assign sum_cur  = sum_arr[ci];
  assign pos_cur  = pos_arr[ci];

  always_comb begin
    if (fill_cur < FILL_W'(WINDOW)) begin
      fill_new = fill_cur + 1'b1;
      sum_new  = sum_cur + SUM_W'(raw_q);
    end else begin
      fill_new = fill_cur;
      sum_new  = sum_cur - SUM_W'(win_rdata) + SUM_W'(raw_q);
    end
    if (pos_cur == POS_W'(WINDOW - 1)) begin
      pos_new = '0;
    end else begin
      pos_new = pos_cur + 1'b1;
    end
  end

  // numerator sum * 5 * 65536 plus half the divisor 65535 * fill
  assign sum5 = {sum_q, 2'b00} + (SUM_W + 3)'(sum_q);
  assign den  = DEN_W'({fill_q, {FRAC_W{1'b0}}}) - DEN_W'(fill_q);
  assign num  = {sum5, {FRAC_W{1'b0}}} + NUM_W'(den >> 1);

  // restoring divide, one quotient bit per step
  assign rem2 = {rem_q, numlo_q[VOLT_W-1]};
  assign qbit = rem2 >= {1'b0, den_q};

  // coefficient read index follows the horner step
  always_comb begin
    case (ctrl.op)
      sapc_pkg::OP_PREP:  idx_rd = '0;
      sapc_pkg::OP_LOADC: idx_rd = sapc_pkg::IDX_W'(1);
      default:            idx_rd = k_q + 1'b1;
    endcase
  end

  assign coef_re    = (ctrl.op == sapc_pkg::OP_PREP) || (ctrl.op == sapc_pkg::OP_LOADC) ||
                      ((ctrl.op == sapc_pkg::OP_ACC) &&
                       (k_q != sapc_pkg::IDX_W'(sapc_pkg::NUM_COEFFS - 1)));
  assign coef_raddr = CA_W'(ch_q) * CA_W'(sapc_pkg::NUM_COEFFS) + CA_W'(idx_rd);
  assign coef_val   = cvld_q ? $signed(coef_rdata) : '0;

  assign volt_s   = $signed({1'b0, numlo_q});
  assign prod_ext = ACC_W'(prod_q);
  assign part_ext = $signed(ACC_W'(part_q >> FRAC_W));
  assign coef_ext = ACC_W'(coef_val);
  // high partial product already carries 2^24, rounding shift leaves 2^8
  assign acc_next = (prod_ext <<< HI_SHIFT) + part_ext + coef_ext;

  assign fits     = (acc_q[ACC_W-1:COEF_W-1] == '0) || (acc_q[ACC_W-1:COEF_W-1] == '1);
  assign disp_sat = fits ? acc_q[COEF_W-1:0] :
                    (acc_q[ACC_W-1] ? sapc_pkg::DISP_MIN : sapc_pkg::DISP_MAX);

  assign out_busy        = out_valid && !rsp.ready;
  assign status.out_busy = out_busy;

  sapc_ram #(
    .WIDTH (sapc_pkg::RAW_W),
    .DEPTH (WIN_DEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (ctrl.op == sapc_pkg::OP_UPDATE),
    .waddr (waddr_q),
    .wdata (raw_q),
    .re    (status.start),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  sapc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (req.coeff_value),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_arr[i]  <= '0;
        fill_arr[i] <= '0;
        sum_arr[i]  <= '0;
      end
      coef_vld  <= '0;
      out_valid <= 1'b0;
      cvld_q    <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      if (coef_re) begin
        cvld_q <= coef_vld[coef_raddr];
      end
      if (ctrl.op == sapc_pkg::OP_UPDATE) begin
        pos_arr[ci]  <= pos_new;
        fill_arr[ci] <= fill_new;
        sum_arr[ci]  <= sum_new;
      end
      if ((ctrl.op == sapc_pkg::OP_EMIT) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (ctrl.op)
      sapc_pkg::OP_FETCH: begin
        if (status.start) begin
          ch_q    <= req.channel;
          raw_q   <= req.raw_sample;
          waddr_q <= win_raddr;
        end
      end
      sapc_pkg::OP_UPDATE: begin
        sum_q  <= sum_new;
        fill_q <= fill_new;
      end
      sapc_pkg::OP_PREP: begin
        den_q   <= den;
        rem_q   <= num[NUM_W-1:VOLT_W];
        numlo_q <= num[VOLT_W-1:0];
      end
      sapc_pkg::OP_DIV: begin
        rem_q   <= qbit ? DEN_W'(rem2 - {1'b0, den_q}) : rem2[DEN_W-1:0];
        numlo_q <= {numlo_q[VOLT_W-2:0], qbit};
      end
      sapc_pkg::OP_LOADC: begin
        acc_q <= coef_ext;
        k_q   <= sapc_pkg::IDX_W'(1);
      end
      sapc_pkg::OP_MUL_LO: begin
        prod_q <= $signed({1'b0, acc_q[HALF_W-1:0]}) * volt_s;
      end
      sapc_pkg::OP_MUL_HI: begin
        prod_q <= $signed(acc_q[ACC_W-1:HALF_W]) * volt_s;
        part_q <= {1'b0, prod_q[PL_W-1:0]} + PART_W'(sapc_pkg::ROUND_HALF);
      end
      sapc_pkg::OP_ACC: begin
        acc_q <= acc_next;
        k_q   <= k_q + 1'b1;
      end
      sapc_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_channel <= ch_q;
          out_volt    <= numlo_q;
          out_disp    <= disp_sat;
          out_sat     <= !fits;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.out_channel  = out_channel;
  assign rsp.avg_volt     = out_volt;
  assign rsp.displacement = out_disp;
  assign rsp.saturated    = out_sat;

`ifndef SYNTH
  a_volt_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.avg_volt <= VOLT_W'(sapc_pkg::VOLT_MAX))
    else $error("averaged voltage above full scale");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.saturated) |->
      (rsp.displacement == sapc_pkg::DISP_MAX || rsp.displacement == sapc_pkg::DISP_MIN))
    else $error("saturated result not at a rail");

  a_div_fill: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == sapc_pkg::OP_DIV) |-> (fill_q != '0 && fill_q <= FILL_W'(WINDOW)))
    else $error("divide with a bad fill count");

  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(ctrl.op == sapc_pkg::OP_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

`default_nettype wire

FILE: sim/sapc_calib_checker.sv
// sapc_calib_checker: watches the request and result channels of the sensor
// conditioner, predicts each result and compares it field by field
// depends on sapc_pkg, sapc_req_if and sapc_rsp_if
module sapc_calib_checker #(
  parameter int NUM_CHANNELS = sapc_pkg::NUM_CHANNELS_DEF,
  parameter int WINDOW       = sapc_pkg::WINDOW_DEF
) (
  input  logic  clk,
  input  logic  rst,
  sapc_req_if   req,
  sapc_rsp_if   rsp,
  output int    fail_count,
  output int    outstanding,
  output int    results_checked,
  output int    clipped_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ADC_FULL = 65535;

  typedef struct {
    logic [sapc_pkg::CH_W-1:0]          ch;
    logic [sapc_pkg::VOLT_W-1:0]        volt;
    logic signed [sapc_pkg::COEF_W-1:0] disp;
    logic                               sat;
  } calib_result_t;

  calib_result_t expected_results[$];
  calib_result_t want;

  // per-channel averaging window and calibration table
  logic [sapc_pkg::RAW_W-1:0]         window_samples [NUM_CHANNELS][WINDOW];
  int unsigned                        win_pos  [NUM_CHANNELS];
  int unsigned                        win_fill [NUM_CHANNELS];
  longint                             win_sum  [NUM_CHANNELS];
  logic signed [sapc_pkg::COEF_W-1:0] coeffs   [NUM_CHANNELS][sapc_pkg::NUM_COEFFS];

  function automatic calib_result_t calibrate_sample(input int unsigned ch,
                                                     input logic [sapc_pkg::RAW_W-1:0] raw);
    calib_result_t r;
    int unsigned   slot;
    longint        num;
    longint        den;
    longint        acc;
    slot = win_pos[ch];
    if (win_fill[ch] < WINDOW) begin
      win_fill[ch]++;
    end else begin
      win_sum[ch] -= longint'(window_samples[ch][slot]);
    end
    window_samples[ch][slot] = raw;
    win_sum[ch] += longint'(raw);
    win_pos[ch] = (slot + 1) % WINDOW;

    // average scaled by 5/65535 into Q3.16, rounded half up
    num = win_sum[ch] * longint'(sapc_pkg::VOLT_MAX);
    den = ADC_FULL * longint'(win_fill[ch]);
    r.volt = sapc_pkg::VOLT_W'((num + den / 2) / den);

    // horner, each product rounded half up back to Q16.16
    acc = longint'(coeffs[ch][0]);
    for (int k = 1; k < sapc_pkg::NUM_COEFFS; k++) begin
      acc = ((acc * longint'(r.volt) + longint'(sapc_pkg::ROUND_HALF)) >>> sapc_pkg::FRAC_W)
            + longint'(coeffs[ch][k]);
    end

    r.sat = 1'b1;
    if (acc > longint'(sapc_pkg::DISP_MAX)) begin
      r.disp = sapc_pkg::DISP_MAX;
    end else if (acc < longint'(sapc_pkg::DISP_MIN)) begin
      r.disp = sapc_pkg::DISP_MIN;
    end else begin
      r.disp = acc[sapc_pkg::COEF_W-1:0];
      r.sat  = 1'b0;
    end
    r.ch = sapc_pkg::CH_W'(ch);
    return r;
  endfunction

  task automatic note_failure(input string what);
    if (fail_count < 10) begin
      $display("%0t ns: %s", $time, what);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        win_pos[c]  = 0;
        win_fill[c] = 0;
        win_sum[c]  = 0;
        for (int k = 0; k < sapc_pkg::NUM_COEFFS; k++) begin
          coeffs[c][k] = '0;
        end
      end
      fail_count      = 0;
      results_checked = 0;
      clipped_results = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: ch %0d volt %0d disp %0d sat %0b",
                                 rsp.out_channel, rsp.avg_volt, rsp.displacement,
                                 rsp.saturated));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (rsp.out_channel !== want.ch || rsp.avg_volt !== want.volt ||
              rsp.displacement !== want.disp || rsp.saturated !== want.sat) begin
            note_failure($sformatf({"result mismatch: ch %0d volt %0d disp %0d sat %0b, ",
                                    "expected ch %0d volt %0d disp %0d sat %0b"},
                                   rsp.out_channel, rsp.avg_volt, rsp.displacement,
                                   rsp.saturated, want.ch, want.volt, want.disp, want.sat));
          end
          results_checked++;
          if (want.sat) begin
            clipped_results++;
          end
        end
      end

      // requests for channels past the last one are dropped by the block
      if (req.valid && req.ready && req.channel < NUM_CHANNELS) begin
        if (req.req_type == sapc_pkg::REQ_COEFF) begin
          if (req.coeff_index < sapc_pkg::NUM_COEFFS) begin
            coeffs[req.channel][req.coeff_index] = req.coeff_value;
          end
        end else begin
          expected_results.insert(expected_results.size(),
                                  calibrate_sample(req.channel, req.raw_sample));
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: sim/sensor_average_poly_calibrate_top_tb.sv
// sensor_average_poly_calibrate_top_tb: drives samples and coefficient writes
// into the sensor conditioner with random gaps and output stalls
// depends on sapc_pkg, sapc_req_if, sapc_rsp_if, the block and sapc_calib_checker
module sensor_average_poly_calibrate_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH       = sapc_pkg::NUM_CHANNELS_DEF;
  localparam int WIN          = sapc_pkg::WINDOW_DEF;
  localparam int RANDOM_REQS  = 1900;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_AT     = 900;
  localparam int STEADY_FIRST = 1000;
  localparam int STEADY_LAST  = 1300;
  localparam int IDLE_PCT     = 12;

  typedef logic [sapc_pkg::CH_W-1:0]          ch_t;
  typedef logic [sapc_pkg::RAW_W-1:0]         raw_t;
  typedef logic [sapc_pkg::IDX_W-1:0]         idx_t;
  typedef logic signed [sapc_pkg::COEF_W-1:0] coef_t;

  // coefficient slots, highest power first
  localparam idx_t TERM_X5      = idx_t'(0);
  localparam idx_t TERM_X4      = idx_t'(1);
  localparam idx_t TERM_CONST   = idx_t'(5);
  localparam idx_t IDX_PAST_END = idx_t'(sapc_pkg::NUM_COEFFS);
  localparam idx_t IDX_TOP      = '1;

  localparam ch_t  CH_LAST      = ch_t'(NUM_CH - 1);
  localparam ch_t  CH_FIRST_BAD = ch_t'(NUM_CH);
  localparam ch_t  CH_TOP       = '1;
  localparam raw_t RAW_FULL     = '1;
  localparam coef_t ONE_Q16     = coef_t'(32'h0001_0000);
  localparam coef_t MINUS_ONE   = coef_t'(-1);

  logic clk;
  logic rst;
  sapc_req_if req_ch ();
  sapc_rsp_if rsp_ch ();

  int fail_count;
  int outstanding;
  int results_checked;
  int clipped_results;

  int reqs_sent    = 0;
  int sample_reqs  = 0;
  int coeff_reqs   = 0;
  int ignored_reqs = 0;
  bit steady       = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;

  sensor_average_poly_calibrate_top #(
    .NUM_CHANNELS(NUM_CH),
    .WINDOW      (WIN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sapc_calib_checker #(
    .NUM_CHANNELS(NUM_CH),
    .WINDOW      (WIN)
  ) calib_chk (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .clipped_results(clipped_results)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #8_000_000;
    $display("FAIL sensor_average_poly_calibrate_top");
    $finish;
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && reqs_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_req(input logic kind, input ch_t ch, input raw_t raw,
                          input idx_t idx, input coef_t value);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.channel     <= ch;
    req_ch.raw_sample  <= raw;
    req_ch.coeff_index <= idx;
    req_ch.coeff_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    reqs_sent++;
    if (ch >= NUM_CH || (kind == sapc_pkg::REQ_COEFF && idx >= sapc_pkg::NUM_COEFFS)) begin
      ignored_reqs++;
    end else if (kind == sapc_pkg::REQ_SAMPLE) begin
      sample_reqs++;
    end else begin
      coeff_reqs++;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic raw_t pick_raw();
    case ($urandom_range(9))
      0: return '0;
      1: return RAW_FULL;
      default: return raw_t'($urandom);
    endcase
  endfunction

  // mostly realistic coefficients so results stay in range, some full scale
  function automatic coef_t pick_coeff();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return coef_t'($urandom_range(524288)) - coef_t'(262144);
      6, 7: return coef_t'($urandom);
      default: return coef_t'($urandom_range(131072)) - coef_t'(65536);
    endcase
  endfunction

  initial begin
    int    useful;
    int    sel;
    ch_t   ch;
    idx_t  idx;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = sapc_pkg::REQ_SAMPLE;
    req_ch.channel     = '0;
    req_ch.raw_sample  = '0;
    req_ch.coeff_index = '0;
    req_ch.coeff_value = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // zero table, then clipping both ways, dropped and ignored requests
    send_req(sapc_pkg::REQ_SAMPLE, '0, '0, '0, '0);
    send_req(sapc_pkg::REQ_COEFF, '0, '0, TERM_X5, sapc_pkg::DISP_MAX);
    send_req(sapc_pkg::REQ_COEFF, '0, '0, TERM_CONST, sapc_pkg::DISP_MIN);
    send_req(sapc_pkg::REQ_SAMPLE, '0, RAW_FULL, '0, '0);
    send_req(sapc_pkg::REQ_COEFF, '0, '0, IDX_PAST_END, ONE_Q16);
    send_req(sapc_pkg::REQ_COEFF, '0, '0, IDX_TOP, MINUS_ONE);
    send_req(sapc_pkg::REQ_SAMPLE, CH_TOP, RAW_FULL, IDX_TOP, MINUS_ONE);
    send_req(sapc_pkg::REQ_COEFF, CH_FIRST_BAD, '0, TERM_X5, ONE_Q16);
    send_req(sapc_pkg::REQ_SAMPLE, CH_FIRST_BAD, '0, '0, '0);
    send_req(sapc_pkg::REQ_COEFF, ch_t'(2), '0, TERM_X5, sapc_pkg::DISP_MIN);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(2), RAW_FULL, '0, '0);
    send_req(sapc_pkg::REQ_COEFF, CH_LAST, '0, TERM_X4, ONE_Q16);
    send_req(sapc_pkg::REQ_SAMPLE, CH_LAST, RAW_FULL, '0, '0);
    // window fills up and wraps around
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(1), RAW_FULL, '0, '0);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(1), '0, '0, '0);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(1), raw_t'(1), '0, '0);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(1), raw_t'(32768), '0, '0);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(1), RAW_FULL, '0, '0);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(1), raw_t'(12345), '0, '0);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(1), '0, '0, '0);
    send_req(sapc_pkg::REQ_COEFF, ch_t'(3), RAW_FULL, TERM_CONST, MINUS_ONE);
    send_req(sapc_pkg::REQ_SAMPLE, ch_t'(3), raw_t'(1), '0, '0);
    drain_results();

    useful = 0;
    while (reqs_sent < RANDOM_REQS) begin
      steady = (useful >= STEADY_FIRST && useful < STEADY_LAST);
      if (reqs_sent == DRAIN_AT) begin
        drain_results();
      end
      sel = $urandom_range(99);
      ch  = ch_t'($urandom_range(NUM_CH - 1));
      idx = idx_t'($urandom_range(sapc_pkg::NUM_COEFFS - 1));
      if (sel < 70) begin
        send_req(sapc_pkg::REQ_SAMPLE, ch, pick_raw(), idx_t'($urandom), coef_t'($urandom));
        useful++;
      end else if (sel < 88) begin
        send_req(sapc_pkg::REQ_COEFF, ch, raw_t'($urandom), idx, pick_coeff());
        useful++;
      end else if (sel < 94) begin
        // channel past the last one, either kind
        send_req(logic'($urandom_range(1)), ch_t'($urandom_range(15, NUM_CH)),
                 raw_t'($urandom), idx_t'($urandom), coef_t'($urandom));
      end else begin
        send_req(sapc_pkg::REQ_COEFF, ch_t'($urandom),
                 raw_t'($urandom), idx_t'($urandom_range(7, sapc_pkg::NUM_COEFFS)),
                 coef_t'($urandom));
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (100) @(negedge clk);

    $display("covered %0d samples, %0d coefficient writes, %0d dropped or ignored requests",
             sample_reqs, coeff_reqs, ignored_reqs);
    $display("checked %0d results, %0d of them clipped, with a %0d-cycle output hold-off",
             results_checked, clipped_results, HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS sensor_average_poly_calibrate_top");
    end else begin
      $display("FAIL sensor_average_poly_calibrate_top");
    end
    $finish;
  end

endmodule
